// ----- rtl/tseb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tseb_pkg
// Shared constants and types for the sorted event buffer.
// ----------------------------------------------------------------------------
package tseb_pkg;
  localparam int MaxEvents     = 256;
  localparam int MaxBytes      = 4096;
  localparam int MaxEventBytes = 64;
  localparam int EIdxW = $clog2(MaxEvents);
  localparam int BAddrW = $clog2(MaxBytes);
  // entry record: time, start, size
  localparam int EntryW = 16 + BAddrW + 7;

  localparam logic [1:0] OpAdd   = 2'd0;
  localparam logic [1:0] OpRead  = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;
  localparam logic [1:0] OpDropR = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StDrop  = 2'd1;
  localparam logic [1:0] StLen   = 2'd2;
  localparam logic [1:0] StRange = 2'd3;

  localparam logic [0:0] CfgEventLimit = 1'b0;
  localparam logic [0:0] CfgByteLimit  = 1'b1;

  typedef struct packed {
    logic [15:0]       time_v;
    logic [BAddrW-1:0] start;
    logic [6:0]        size;
  } entry_t;
endpackage
`default_nettype wire

// ----- rtl/timestamp_sorted_event_buffer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timestamp_sorted_event_buffer_top
// Byte event buffer kept in stable sample-offset order.
//
// channel   direction  handshake         payload
// command   in         start & !busy     operation, sample_offset, byte_count,
//                                        data_byte, index
// result    out        strobe (1 cycle)  status .. last
// config    in         cfg_valid&ready   cfg_index, cfg_data
//
// Add byte: the result leaves through SDone; the final byte of a kept event adds an
// insertion walk through SWalkR and SWalkC for each entry moved (entry RAM has one read and one
// write port). Read: lookup through SRdA and SRdB, then one byte per cycle from SRdOut.
// Others: the result leaves through SDone.
// Reset is synchronous; the stores need no clearing pass. No stall on output.
// ----------------------------------------------------------------------------
module timestamp_sorted_event_buffer_top
  import tseb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation,
  input  wire logic [15:0] sample_offset,
  input  wire logic [6:0]  byte_count,
  input  wire logic [7:0]  data_byte,
  input  wire logic [7:0]  index,
  output logic             strobe,
  output logic [1:0]       status,
  output logic [15:0]      event_offset,
  output logic [6:0]       event_length,
  output logic [7:0]       out_byte,
  output logic [8:0]       stored_events,
  output logic [15:0]      drop_total,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SWalkR = 3'd1;
  localparam logic [2:0] SWalkC = 3'd2;
  localparam logic [2:0] SRdA   = 3'd3;
  localparam logic [2:0] SRdB   = 3'd4;
  localparam logic [2:0] SRdOut = 3'd5;
  localparam logic [2:0] SDone  = 3'd6;

  logic [2:0]  state;
  logic [8:0]  event_limit;
  logic [12:0] byte_limit;
  logic [8:0]  held;
  logic [12:0] used;
  logic [15:0] drops;
  logic [6:0]  remaining;
  logic        discarding;
  logic [15:0] pend_time;
  logic [6:0]  pend_size;
  logic [6:0]  pend_written;
  logic [8:0]  pos;
  logic [6:0]  rd_k;
  logic [6:0]  rd_len;
  logic [BAddrW-1:0] rd_addr;
  logic [15:0] rd_time;

  // entry RAM ports
  logic              e_we;
  logic [EIdxW-1:0]  e_waddr, e_raddr;
  entry_t            e_wdata, e_rdata;
  // byte RAM ports
  logic              b_we;
  logic [BAddrW-1:0] b_waddr, b_raddr;
  logic [7:0]        b_rdata;

  tseb_ram #(.Width(EntryW), .Depth(MaxEvents)) u_entries (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata));
  tseb_ram #(.Width(8), .Depth(MaxBytes)) u_bytes (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(data_byte),
    .raddr(b_raddr), .rdata(b_rdata));

  assign busy      = (state != SIdle);
  assign cfg_ready = 1'b1;
  assign stored_events = held;
  assign drop_total    = drops;

  // first-byte checks
  logic        first;
  logic        bad_len;
  logic [8:0]  ecap;
  logic [12:0] bcap;
  logic        no_room;
  logic [13:0] need;
  assign first   = (remaining == 7'd0);
  assign bad_len = (byte_count == 7'd0) || (byte_count > 7'(MaxEventBytes));
  assign ecap    = (event_limit < 9'(MaxEvents)) ? event_limit : 9'(MaxEvents);
  assign bcap    = (byte_limit < 13'(MaxBytes)) ? byte_limit : 13'(MaxBytes);
  assign need    = {1'b0, used} + {7'd0, byte_count};
  assign no_room = (held >= ecap) || (need > {1'b0, bcap});

  logic accept;
  assign accept = start && !busy;

  logic [6:0]  eff_rem;
  logic        eff_disc;
  logic [15:0] eff_time;
  logic [6:0]  eff_size;
  logic [6:0]  eff_written;
  always_comb begin
    eff_rem     = remaining;
    eff_disc    = discarding;
    eff_time    = pend_time;
    eff_size    = pend_size;
    eff_written = pend_written;
    if (first) begin
      eff_rem     = byte_count;
      eff_disc    = no_room;
      eff_time    = sample_offset;
      eff_size    = byte_count;
      eff_written = 7'd0;
    end
  end

  logic [12:0] waddr_full;
  assign waddr_full = used + {6'd0, eff_written};

  always_comb begin
    b_we    = accept && (operation == OpAdd) && !(first && bad_len) && !eff_disc;
    b_waddr = waddr_full[BAddrW-1:0];
    b_raddr = rd_addr;
    e_raddr = (state == SIdle) ? index : EIdxW'(pos - 9'd1);
    e_we    = 1'b0;
    e_waddr = pos[EIdxW-1:0];
    e_wdata = e_rdata;
    if (state == SWalkC) begin
      e_we = 1'b1;
      if (pos == 9'd0 || e_rdata.time_v <= pend_time) begin
        e_wdata.time_v = pend_time;
        e_wdata.start  = used[BAddrW-1:0];
        e_wdata.size   = pend_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= SIdle;
      event_limit <= 9'd256;
      byte_limit  <= 13'd4096;
      held        <= '0;
      used        <= '0;
      drops       <= '0;
      remaining   <= '0;
      discarding  <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgEventLimit) event_limit <= cfg_data[8:0];
        else byte_limit <= cfg_data[12:0];
      end
      unique case (state)
        SIdle: if (accept) begin
          status       <= StOk;
          event_offset <= '0;
          event_length <= '0;
          out_byte     <= '0;
          last         <= 1'b1;
          case (operation)
            OpAdd: begin
              if (first && bad_len) begin
                status       <= StLen;
                event_offset <= sample_offset;
                state        <= SDone;
              end else begin
                status       <= eff_disc ? StDrop : StOk;
                event_offset <= eff_time;
                event_length <= eff_size;
                pend_time    <= eff_time;
                pend_size    <= eff_size;
                pend_written <= eff_written + 7'(!eff_disc);
                discarding   <= eff_disc;
                remaining    <= eff_rem - 7'd1;
                if (first && no_room && drops != 16'hFFFF) drops <= drops + 16'd1;
                if (eff_rem == 7'd1 && !eff_disc) begin
                  pos   <= held;
                  state <= (held == 9'd0) ? SWalkC : SWalkR;
                end else begin
                  state <= SDone;
                end
              end
            end
            OpRead: begin
              if ({1'b0, index} >= held) begin
                status <= StRange;
                state  <= SDone;
              end else begin
                // entry address is pos - 1 outside idle
                pos   <= {1'b0, index} + 9'd1;
                state <= SRdA;
              end
            end
            OpClear: begin
              held       <= '0;
              used       <= '0;
              remaining  <= '0;
              discarding <= 1'b0;
              state      <= SDone;
            end
            default: begin
              drops <= '0;
              state <= SDone;
            end
          endcase
        end
        SWalkR: state <= SWalkC;
        SWalkC: begin
          if (pos == 9'd0 || e_rdata.time_v <= pend_time) begin
            used      <= used + {6'd0, pend_size};
            held      <= held + 9'd1;
            remaining <= '0;
            state     <= SDone;
          end else begin
            pos   <= pos - 9'd1;
            state <= (pos == 9'd1) ? SWalkC : SWalkR;
          end
        end
        SRdA: state <= SRdB;
        SRdB: begin
          rd_time <= e_rdata.time_v;
          rd_len  <= (e_rdata.size > 7'(MaxEventBytes)) ? 7'(MaxEventBytes)
                     : e_rdata.size;
          rd_addr <= e_rdata.start;
          rd_k    <= '0;
          if (e_rdata.size == 7'd0) begin
            event_offset <= e_rdata.time_v;
            state        <= SDone;
          end else begin
            state <= SRdOut;
          end
        end
        SRdOut: begin
          // byte at rd_addr is ready in the cycle after the address was set
          state <= SRdOut;
          if (rd_k == 7'd0) begin
            rd_k    <= 7'd1;
            rd_addr <= rd_addr + BAddrW'(1);
          end else begin
            strobe       <= 1'b1;
            status       <= StOk;
            event_offset <= rd_time;
            event_length <= rd_len;
            out_byte     <= b_rdata;
            last         <= (rd_k == rd_len);
            rd_addr      <= rd_addr + BAddrW'(1);
            rd_k         <= rd_k + 7'd1;
            if (rd_k == rd_len) state <= SIdle;
          end
        end
        SDone: begin
          strobe <= 1'b1;
          state  <= SIdle;
        end
        default: state <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/tseb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tseb_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module tseb_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/tseb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tseb_checker
// Port-level checks for the sorted event buffer.
// ----------------------------------------------------------------------------
module tseb_checker
  import tseb_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       strobe,
  input wire logic       last,
  input wire logic [1:0] status,
  input wire logic [8:0] stored_events,
  input wire logic [6:0] event_length
);
  // a transfer in makes the block busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("not busy after transfer");
  a_range: assert property (@(posedge clk) disable iff (rst)
    strobe && status == StRange |-> event_length == 7'd0 && last)
    else $error("bad out-of-range result");
  a_cap: assert property (@(posedge clk) disable iff (rst)
    stored_events <= 9'(MaxEvents)) else $error("count above capacity");
  a_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe) else $error("result after last");
endmodule

bind timestamp_sorted_event_buffer_top tseb_checker u_chk (
  .clk, .rst, .start, .busy, .strobe, .last, .status, .stored_events,
  .event_length);
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted event buffer. Events are pushed one byte
// per command and read back by sorted index; a behavioural copy of the buffer
// predicts every result. Runs directed corner cases, then random traffic
// under several sender idling patterns and limit settings.
// ----------------------------------------------------------------------------
module tb_top;
  import tseb_pkg::*;

  typedef struct packed {
    logic [1:0]  st;
    logic [15:0] ofs;
    logic [6:0]  len;
    logic [7:0]  data;
    logic [8:0]  held;
    logic [15:0] drp;
    logic        lst;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  operation;
  logic [15:0] sample_offset;
  logic [6:0]  byte_count;
  logic [7:0]  data_byte;
  logic [7:0]  index;
  logic        strobe;
  logic [1:0]  status;
  logic [15:0] event_offset;
  logic [6:0]  event_length;
  logic [7:0]  out_byte;
  logic [8:0]  stored_events;
  logic [15:0] drop_total;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  timestamp_sorted_event_buffer_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .sample_offset(sample_offset),
    .byte_count(byte_count), .data_byte(data_byte), .index(index),
    .strobe(strobe), .status(status), .event_offset(event_offset),
    .event_length(event_length), .out_byte(out_byte),
    .stored_events(stored_events), .drop_total(drop_total), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // behavioural copy of the buffer
  logic [15:0] m_time [MaxEvents];
  logic [11:0] m_start [MaxEvents];
  logic [6:0]  m_size [MaxEvents];
  logic [7:0]  m_bytes [MaxBytes];
  int          m_held, m_used, m_drops, m_remaining, m_pend_time, m_pend_size;
  int          m_written;
  bit          m_discard;
  int          lim_events, lim_bytes;

  outcome_t    pending_results[$];
  int          errors, sent_items, seen_results, cycles;
  int          idle_pct;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
             seen_results);
    errors++;
  endtask

  function automatic void push_result(logic [1:0] st, int ofs, int len, int data,
                                      bit lst);
    outcome_t r;
    r.st = st; r.ofs = ofs[15:0]; r.len = len[6:0]; r.data = data[7:0];
    r.held = m_held[8:0]; r.drp = m_drops[15:0]; r.lst = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void clear_pending();
    m_remaining = 0; m_discard = 0; m_pend_time = 0; m_pend_size = 0; m_written = 0;
  endfunction

  function automatic void predict(logic [1:0] op, int ofs, int cnt, int b, int idx);
    int ecap, bcap, pos, len;
    logic [1:0] st;
    if (op == OpAdd) begin
      if (m_remaining == 0) begin
        ecap = lim_events < MaxEvents ? lim_events : MaxEvents;
        bcap = lim_bytes < MaxBytes ? lim_bytes : MaxBytes;
        if (cnt == 0 || cnt > MaxEventBytes) begin
          push_result(StLen, ofs, 0, 0, 1);
          return;
        end
        m_pend_time = ofs; m_pend_size = cnt; m_written = 0; m_remaining = cnt;
        m_discard = (m_held >= ecap) || (m_used + cnt > bcap);
        if (m_discard && m_drops < 16'hFFFF) m_drops++;
      end
      if (m_discard) begin
        st = StDrop;
      end else begin
        if (m_used + m_written < MaxBytes) m_bytes[m_used + m_written] = b[7:0];
        m_written++;
        st = StOk;
      end
      m_remaining--;
      ofs = m_pend_time; cnt = m_pend_size;
      if (m_remaining == 0) begin
        if (!m_discard) begin
          // stable insert: walk past every entry with a later offset
          pos = m_held;
          while (pos > 0 && m_time[pos-1] > m_pend_time) begin
            m_time[pos] = m_time[pos-1]; m_start[pos] = m_start[pos-1];
            m_size[pos] = m_size[pos-1];
            pos--;
          end
          m_time[pos] = 16'(m_pend_time); m_start[pos] = 12'(m_used);
          m_size[pos] = 7'(m_pend_size);
          m_used += m_pend_size;
          m_held++;
        end
        clear_pending();
      end
      push_result(st, ofs, cnt, 0, 1);
    end else if (op == OpRead) begin
      if (idx >= m_held) begin
        push_result(StRange, 0, 0, 0, 1);
      end else begin
        len = m_size[idx];
        if (len == 0) push_result(StOk, m_time[idx], 0, 0, 1);
        for (int k = 0; k < len; k++)
          push_result(StOk, m_time[idx], len, m_bytes[(m_start[idx] + k) % MaxBytes],
                      k + 1 == len);
      end
    end else begin
      if (op == OpClear) begin
        m_held = 0; m_used = 0;
        clear_pending();
      end else begin
        m_drops = 0;
      end
      push_result(StOk, 0, 0, 0, 1);
    end
  endfunction

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && strobe) begin
      seen_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = pending_results.pop_front();
        if (status !== e.st) report_mismatch("status", status, e.st);
        if (event_offset !== e.ofs) report_mismatch("event_offset", event_offset, e.ofs);
        if (event_length !== e.len) report_mismatch("event_length", event_length, e.len);
        if (out_byte !== e.data) report_mismatch("out_byte", out_byte, e.data);
        if (stored_events !== e.held)
          report_mismatch("stored_events", stored_events, e.held);
        if (drop_total !== e.drp) report_mismatch("drop_total", drop_total, e.drp);
        if (last !== e.lst) report_mismatch("last", last, e.lst);
      end
    end
  end

  // one command transfer; start stays high if the caller sends again at once
  task automatic send_command(logic [1:0] op, int ofs, int cnt, int b, int idx);
    @(negedge clk);
    start <= 1'b1;
    operation <= op; sample_offset <= ofs[15:0]; byte_count <= cnt[6:0];
    data_byte <= b[7:0]; index <= idx[7:0];
    do @(posedge clk); while (busy);
    predict(op, ofs, cnt, b, idx);
    sent_items++;
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
  endtask

  task automatic send_event(int ofs, int len);
    for (int k = 0; k < len; k++)
      send_command(OpAdd, ofs, len, $urandom_range(255), 0);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic [0:0] reg_sel, int value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= reg_sel; cfg_data <= value[15:0];
    do @(posedge clk); while (!cfg_ready);
    if (reg_sel == CfgEventLimit) lim_events = value & 9'h1FF;
    else lim_bytes = value & 13'h1FFF;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_event(16'hFFFF, MaxEventBytes);
    send_command(OpAdd, 0, 0, 8'hFF, 0);          // zero length
    send_command(OpAdd, 1234, 7'h7F, 0, 0);       // over-long event
    send_event(0, 1);
    send_event(100, 2);
    send_command(OpAdd, 100, 3, 8'h00, 0);        // tie with offset 100
    send_command(OpRead, 0, 0, 0, 1);             // read mid-event
    send_command(OpAdd, 16'h5A5A, 7'h40, 8'hFF, 0); // latched fields kept
    send_command(OpAdd, 7, 1, 8'h81, 0);
    send_command(OpDropR, 0, 0, 0, 0);
    for (int i = 0; i < 4; i++) send_command(OpRead, 0, 0, 0, i);
    send_command(OpRead, 0, 0, 0, 255);
    send_command(OpAdd, 50, 5, 1, 0);
    send_command(OpClear, 0, 0, 0, 0);            // abandons the event
    send_command(OpRead, 0, 0, 0, 0);
  endtask

  task automatic test_limits();
    write_limit(CfgEventLimit, 0);
    send_event(9, 2);                             // no entry room
    send_command(OpDropR, 0, 0, 0, 0);
    write_limit(CfgEventLimit, 511);
    write_limit(CfgByteLimit, 0);
    send_event(9, 1);
    write_limit(CfgByteLimit, 8191);
    send_event(3, 1);
    write_limit(CfgByteLimit, 2);                 // too small for the next event
    send_event(4, 2);
    send_command(OpRead, 0, 0, 0, 0);
    write_limit(CfgByteLimit, MaxBytes);
    write_limit(CfgEventLimit, MaxEvents);
  endtask

  task automatic random_traffic(int quota, int pct);
    int target, pick, len;
    idle_pct = pct;
    target = sent_items + quota;
    while (sent_items < target) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(1, MaxEventBytes)
                                       : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(9) == 0) send_command(OpRead, 0, 0, 0, $urandom_range(15));
          send_command(OpAdd, $urandom_range(7) == 0 ? $urandom_range(16'hFFFF)
                                                      : $urandom_range(3) * 16,
                       k == 0 ? len : $urandom_range(127), $urandom_range(255), 0);
        end
      end else if (pick < 82) begin
        send_command(OpRead, 0, 0, 0, $urandom_range(3) == 0 ? $urandom_range(255)
                                                             : $urandom_range(m_held));
      end else if (pick < 86) begin
        send_command(OpAdd, $urandom_range(16'hFFFF), $urandom_range(65, 127),
                     $urandom_range(255), 0);
      end else if (pick < 89) begin
        send_command(OpClear, 0, 0, 0, 0);
      end else if (pick < 92) begin
        send_command(OpDropR, 0, 0, 0, 0);
      end else begin
        send_command(2'($urandom_range(3)), $urandom_range(16'hFFFF),
                     $urandom_range(127), $urandom_range(255), $urandom_range(255));
      end
    end
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; operation = OpAdd; sample_offset = '0;
    byte_count = '0; data_byte = '0; index = '0; cfg_valid = 1'b0;
    cfg_index = CfgEventLimit; cfg_data = '0;
    errors = 0; sent_items = 0; seen_results = 0; cycles = 0; idle_pct = 0;
    lim_events = MaxEvents; lim_bytes = MaxBytes;
    m_held = 0; m_used = 0; m_drops = 0;
    clear_pending();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_limits();
    random_traffic(30, 0);
    write_limit(CfgEventLimit, 6);
    write_limit(CfgByteLimit, 40);
    random_traffic(30, 69);
    write_limit(CfgEventLimit, MaxEvents);
    write_limit(CfgByteLimit, 120);
    random_traffic(30, 15);
    write_limit(CfgByteLimit, MaxBytes);
    random_traffic(30, 0);
    drain();

    $display("covered %0d commands and %0d results: directed corners, limit changes,",
             sent_items, seen_results);
    $display("random traffic with sender idling of 0, 15 and 69 percent");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
